// ===== hw/rtl/btu_pkg.sv =====
// Shared constants and types for the bit-timed 8N1 serial block with receive FIFO.
`default_nettype none

package btu_pkg;

   // Stream and register port widths.
   localparam int REQ_DATA_W   = 16;
   localparam int REQ_USER_W   = 2;
   localparam int RSP_DATA_W   = 24;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 16;
   localparam int BIT_PERIOD_W = 16;
   localparam int COUNT_W      = 6;

   // Commands carried with each tick.
   localparam logic [REQ_USER_W-1:0] CMD_TICK      = 2'd0;
   localparam logic [REQ_USER_W-1:0] CMD_SEND      = 2'd1;
   localparam logic [REQ_USER_W-1:0] CMD_POP       = 2'd2;
   localparam logic [REQ_USER_W-1:0] CMD_CLEAR_OVF = 2'd3;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_BIT_PERIOD    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INVERSE_LOGIC = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LISTEN_ENABLE = 2'd2;

   // Result beat, lowest field last so that it maps straight onto tdata.
   typedef struct packed {
      logic [4:0]         pad;
      logic               rx_busy;
      logic               overflow_flag;
      logic [COUNT_W-1:0] fifo_count;
      logic [7:0]         front_byte;
      logic               send_accepted;
      logic               tx_busy;
      logic               tx_level;
   } rsp_type;

endpackage

`default_nettype wire

// ===== hw/rtl/bit_timed_uart_8n1_with_rx_fifo.sv =====
// Top level: 8N1 serial transmitter and receiver timed in ticks, with a receive FIFO.
//
//   Channel  Direction  Handshake            Contents
//   req      in         req_tvalid/tready    one tick: command, byte to send, rx line level
//   rsp      out        rsp_tvalid/tready    line and FIFO status for that tick
//   csr      in         csr_valid/ready      register index and write data
//
// Each accepted req beat is one tick of the bit timer; a beat can be taken every cycle
// while the skid register is empty. Its rsp beat comes from a result register backed by
// a skid register, so req_tready depends only on whether the skid register is occupied.
// The FIFO is read synchronously into the result or skid register at the accepting edge.
// Reset is synchronous: control state clears, FIFO contents stay undefined until written.
// A stalled rsp side holds two results before req_tready drops; csr_ready is always high.
`default_nettype none

module bit_timed_uart_8n1_with_rx_fifo #(
   parameter int FIFO_DEPTH = 64
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // req_tdata: [7:0] send_byte, [8] rx_level, [15:9] zero
   input  wire logic                                req_tvalid,
   output      logic                                req_tready,
   input  wire logic [btu_pkg::REQ_DATA_W-1:0]      req_tdata,
   // req_tuser: [1:0] cmd
   input  wire logic [btu_pkg::REQ_USER_W-1:0]      req_tuser,
   // rsp_tdata: [0] tx_level, [1] tx_busy, [2] send_accepted, [10:3] front_byte,
   // [16:11] fifo_count, [17] overflow_flag, [18] rx_busy, [23:19] zero
   output      logic                                rsp_tvalid,
   input  wire logic                                rsp_tready,
   output      logic [btu_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  wire logic                                csr_valid,
   output      logic                                csr_ready,
   input  wire logic [btu_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [btu_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   import btu_pkg::*;

   localparam int IDX_W  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int FILL_W = (IDX_W > COUNT_W) ? IDX_W : COUNT_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FIFO_DEPTH - 1);
   localparam logic [IDX_W:0]   DEPTH_EXT = (IDX_W + 1)'(FIFO_DEPTH);

   // Receiver states.
   localparam logic [1:0] RX_IDLE   = 2'd0;
   localparam logic [1:0] RX_CENTER = 2'd1;
   localparam logic [1:0] RX_DATA   = 2'd2;
   localparam logic [1:0] RX_STOP   = 2'd3;

   // Transmit bit positions: idle, start, eight data bits, stop.
   localparam logic [3:0] TX_IDLE_IDX  = 4'd0;
   localparam logic [3:0] TX_START_IDX = 4'd1;
   localparam logic [3:0] TX_STOP_IDX  = 4'd10;

   // Registers and their next values.
   logic [BIT_PERIOD_W-1:0] bit_period_ff;
   logic                    inverse_ff;
   logic                    listen_ff;

   logic [7:0]              fifo_mem [FIFO_DEPTH];
   logic [IDX_W-1:0]        wr_idx_ff, wr_idx_in;
   logic [IDX_W-1:0]        rd_idx_ff, rd_idx_in;
   logic                    ovf_ff, ovf_in;

   logic [1:0]              rx_phase_ff, rx_phase_in;
   logic [BIT_PERIOD_W-1:0] rx_cnt_ff, rx_cnt_in;
   logic [7:0]              rx_shift_ff, rx_shift_in;
   logic [3:0]              rx_bit_ff, rx_bit_in;

   logic [BIT_PERIOD_W-1:0] tx_cnt_ff, tx_cnt_in;
   logic [7:0]              tx_shift_ff, tx_shift_in;
   logic [3:0]              tx_bit_ff, tx_bit_in;

   rsp_type                 main_ff, skid_ff, res_in;
   logic                    main_valid_ff, skid_valid_ff;

   // Combinational working signals.
   logic                    req_accept;
   logic                    main_pop;
   logic                    csr_write;
   logic                    listen_wr;
   logic [1:0]              cmd;
   logic [7:0]              send_byte;
   logic                    rx_level;
   logic                    bp_zero;
   logic [BIT_PERIOD_W-1:0] bp_half;
   logic [BIT_PERIOD_W-1:0] bp_half_min1;
   logic [BIT_PERIOD_W+1:0] bp_times3;
   logic [BIT_PERIOD_W-1:0] bp_3q;
   logic [BIT_PERIOD_W-1:0] bp_3q_min1;
   logic [IDX_W:0]          fill;
   logic [FILL_W-1:0]       fill_wide;
   logic                    fifo_empty;
   logic [IDX_W-1:0]        wr_idx_next;
   logic                    rx_push;
   logic                    mem_we;
   logic                    tx_busy_pre;
   logic                    send_ok;
   logic [3:0]              tx_bit_cur;
   logic [BIT_PERIOD_W-1:0] tx_cnt_cur;
   logic [7:0]              tx_shift_cur;
   logic                    tx_level;

   function automatic rsp_type with_front(rsp_type r, logic [7:0] front);
      r.front_byte = front;
      return r;
   endfunction

   assign cmd        = req_tuser;
   assign send_byte  = req_tdata[7:0];
   assign rx_level   = req_tdata[8];

   assign req_tready = !skid_valid_ff;
   assign req_accept = req_tvalid && req_tready;
   assign main_pop   = main_valid_ff && rsp_tready;
   assign rsp_tvalid = main_valid_ff;
   assign rsp_tdata  = main_ff;
   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid;
   assign listen_wr  = csr_write && (csr_index == CSR_LISTEN_ENABLE);

   // Wait lengths derived from the bit period, never shorter than one tick.
   assign bp_zero      = (bit_period_ff == '0);
   assign bp_half      = bit_period_ff >> 1;
   assign bp_half_min1 = (bp_half == '0) ? BIT_PERIOD_W'(1) : bp_half;
   assign bp_times3    = {2'b00, bit_period_ff} + {1'b0, bit_period_ff, 1'b0};
   assign bp_3q        = bp_times3[BIT_PERIOD_W+1:2];
   assign bp_3q_min1   = (bp_3q == '0) ? BIT_PERIOD_W'(1) : bp_3q;

   // FIFO fill level; one slot always stays empty.
   always_comb begin
      if (wr_idx_ff >= rd_idx_ff) begin
         fill = {1'b0, wr_idx_ff} - {1'b0, rd_idx_ff};
      end else begin
         fill = DEPTH_EXT - {1'b0, rd_idx_ff} + {1'b0, wr_idx_ff};
      end
      fill_wide = FILL_W'(fill);
   end
   assign fifo_empty  = (wr_idx_ff == rd_idx_ff);
   assign wr_idx_next = (wr_idx_ff == LAST_IDX) ? '0 : wr_idx_ff + 1'b1;

   // Transmitter: the send is taken first, then the line level is shown, then time advances.
   always_comb begin
      tx_busy_pre  = (tx_bit_ff != TX_IDLE_IDX) && !bp_zero;
      send_ok      = (cmd == CMD_SEND) && !tx_busy_pre && !bp_zero;
      tx_bit_cur   = bp_zero ? TX_IDLE_IDX : tx_bit_ff;
      tx_cnt_cur   = tx_cnt_ff;
      tx_shift_cur = tx_shift_ff;
      if (send_ok) begin
         tx_bit_cur   = TX_START_IDX;
         tx_cnt_cur   = bit_period_ff;
         tx_shift_cur = send_byte;
      end

      if (tx_bit_cur == TX_IDLE_IDX || tx_bit_cur >= TX_STOP_IDX) begin
         tx_level = !inverse_ff;
      end else if (tx_bit_cur == TX_START_IDX) begin
         tx_level = inverse_ff;
      end else begin
         tx_level = tx_shift_cur[0] ^ inverse_ff;
      end

      tx_bit_in   = tx_bit_cur;
      tx_cnt_in   = tx_cnt_cur;
      tx_shift_in = tx_shift_cur;
      if (tx_bit_cur != TX_IDLE_IDX) begin
         if (tx_cnt_cur > BIT_PERIOD_W'(1)) begin
            tx_cnt_in = tx_cnt_cur - 1'b1;
         end else begin
            if (tx_bit_cur > TX_START_IDX && tx_bit_cur < TX_STOP_IDX) begin
               tx_shift_in = tx_shift_cur >> 1;
            end
            tx_bit_in = (tx_bit_cur >= TX_STOP_IDX) ? TX_IDLE_IDX : tx_bit_cur + 1'b1;
            tx_cnt_in = bit_period_ff;
         end
      end
   end

   // Receiver and FIFO pointers. Pop and clear act before a finished byte is stored.
   always_comb begin
      rd_idx_in   = rd_idx_ff;
      ovf_in      = ovf_ff;
      if (cmd == CMD_POP && !fifo_empty) begin
         rd_idx_in = (rd_idx_ff == LAST_IDX) ? '0 : rd_idx_ff + 1'b1;
      end else if (cmd == CMD_CLEAR_OVF) begin
         ovf_in = 1'b0;
      end

      rx_phase_in = rx_phase_ff;
      rx_cnt_in   = rx_cnt_ff;
      rx_shift_in = rx_shift_ff;
      rx_bit_in   = rx_bit_ff;
      rx_push     = 1'b0;
      if (!listen_ff || bp_zero) begin
         rx_phase_in = RX_IDLE;
      end else if (rx_phase_ff == RX_IDLE) begin
         if (rx_level == inverse_ff) begin
            rx_phase_in = RX_CENTER;
            rx_cnt_in   = bp_half_min1;
         end
      end else if (rx_cnt_ff > BIT_PERIOD_W'(1)) begin
         rx_cnt_in = rx_cnt_ff - 1'b1;
      end else begin
         unique case (rx_phase_ff)
            RX_CENTER: begin
               // A start level that is gone at mid-bit was a glitch.
               if (rx_level != inverse_ff) begin
                  rx_phase_in = RX_IDLE;
               end else begin
                  rx_phase_in = RX_DATA;
                  rx_bit_in   = 4'd0;
                  rx_shift_in = 8'd0;
                  rx_cnt_in   = bit_period_ff;
               end
            end
            RX_DATA: begin
               rx_shift_in = {rx_level ^ inverse_ff, rx_shift_ff[7:1]};
               rx_bit_in   = rx_bit_ff + 1'b1;
               if (rx_bit_ff >= 4'd7) begin
                  rx_phase_in = RX_STOP;
                  rx_cnt_in   = bp_3q_min1;
               end else begin
                  rx_cnt_in = bit_period_ff;
               end
            end
            RX_STOP: begin
               rx_push     = 1'b1;
               rx_phase_in = RX_IDLE;
            end
            default: begin
               rx_phase_in = RX_IDLE;
            end
         endcase
      end

      wr_idx_in = wr_idx_ff;
      mem_we    = 1'b0;
      if (rx_push) begin
         if (wr_idx_next == rd_idx_in) begin
            ovf_in = 1'b1;
         end else begin
            mem_we    = 1'b1;
            wr_idx_in = wr_idx_next;
         end
      end
   end

   // Result for this tick; the front byte is filled in by the synchronous memory read.
   always_comb begin
      res_in               = '0;
      res_in.tx_level      = tx_level;
      res_in.tx_busy       = (tx_bit_cur != TX_IDLE_IDX);
      res_in.send_accepted = send_ok;
      res_in.fifo_count    = fill_wide[COUNT_W-1:0];
      res_in.overflow_flag = ovf_ff;
      res_in.rx_busy       = (rx_phase_ff != RX_IDLE);
   end

   always_ff @(posedge clock) begin
      if (req_accept && mem_we) begin
         fifo_mem[wr_idx_ff] <= rx_shift_ff;
      end
   end

   // Result register with a skid register behind it.
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (main_pop) begin
            main_ff       <= skid_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (req_accept) begin
         if (!main_valid_ff || main_pop) begin
            main_ff       <= with_front(res_in, fifo_empty ? 8'd0 : fifo_mem[rd_idx_ff]);
            main_valid_ff <= 1'b1;
         end else begin
            skid_ff       <= with_front(res_in, fifo_empty ? 8'd0 : fifo_mem[rd_idx_ff]);
            skid_valid_ff <= 1'b1;
         end
      end else if (main_pop) begin
         main_valid_ff <= 1'b0;
      end
   end

   // Tick state advances on each accepted beat; register writes take priority.
   always_ff @(posedge clock) begin
      if (reset) begin
         bit_period_ff <= '0;
         inverse_ff    <= 1'b0;
         listen_ff     <= 1'b0;
         wr_idx_ff     <= '0;
         rd_idx_ff     <= '0;
         ovf_ff        <= 1'b0;
         rx_phase_ff   <= RX_IDLE;
         rx_cnt_ff     <= '0;
         rx_shift_ff   <= '0;
         rx_bit_ff     <= '0;
         tx_cnt_ff     <= '0;
         tx_shift_ff   <= '0;
         tx_bit_ff     <= TX_IDLE_IDX;
      end else begin
         if (listen_wr && csr_wdata[0]) begin
            // Enabling the receiver empties the FIFO.
            wr_idx_ff <= '0;
            rd_idx_ff <= '0;
            ovf_ff    <= 1'b0;
         end else if (req_accept) begin
            wr_idx_ff <= wr_idx_in;
            rd_idx_ff <= rd_idx_in;
            ovf_ff    <= ovf_in;
         end
         if (listen_wr && !csr_wdata[0]) begin
            // Disabling the receiver drops a frame in progress.
            rx_phase_ff <= RX_IDLE;
         end else if (req_accept) begin
            rx_phase_ff <= rx_phase_in;
         end
         if (req_accept) begin
            rx_cnt_ff   <= rx_cnt_in;
            rx_shift_ff <= rx_shift_in;
            rx_bit_ff   <= rx_bit_in;
            tx_cnt_ff   <= tx_cnt_in;
            tx_shift_ff <= tx_shift_in;
            tx_bit_ff   <= tx_bit_in;
         end
         if (csr_write) begin
            unique case (csr_index)
               CSR_BIT_PERIOD: begin
                  bit_period_ff <= csr_wdata[BIT_PERIOD_W-1:0];
               end
               CSR_INVERSE_LOGIC: begin
                  inverse_ff <= csr_wdata[0];
               end
               CSR_LISTEN_ENABLE: begin
                  listen_ff <= csr_wdata[0];
               end
               default: begin
               end
            endcase
         end
      end
   end

endmodule

`default_nettype wire

// ===== dv/uart_status_checker.sv =====
// Checker for the bit-timed serial block: predicts each tick's status beat and compares it.
`timescale 1ns / 100ps

module uart_status_checker #(
   parameter int FIFO_DEPTH = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic [btu_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic [btu_pkg::REQ_USER_W-1:0]      req_tuser,
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [btu_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [btu_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [btu_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output int                                  fail_count,
   output int                                  open_count
);

   import btu_pkg::*;

   typedef enum logic [1:0] {RX_IDLE, RX_CENTER, RX_DATA, RX_STOP} rx_state_type;

   // Transmit frame position: 0 is idle, 1 the start bit, 2 to 9 data bits, 10 the stop bit.
   localparam int unsigned TX_OFF   = 0;
   localparam int unsigned TX_START = 1;
   localparam int unsigned TX_STOP  = 10;

   // Register copies.
   int unsigned baud_ticks;
   bit          line_inverted;
   bit          listening;

   // Receive side.
   logic [7:0]   rx_fifo_mem [FIFO_DEPTH];
   int unsigned  rx_wr_ptr;
   int unsigned  rx_rd_ptr;
   bit           overrun_seen;
   rx_state_type rx_state;
   int unsigned  rx_wait;
   logic [7:0]   rx_sr;
   int unsigned  rx_bits;

   // Transmit side.
   int unsigned tx_wait;
   logic [7:0]  tx_sr;
   int unsigned tx_slot;

   rsp_type expected_status_q [$];
   int      mismatch_count;
   int      beat_no;

   assign fail_count = mismatch_count;

   initial begin
      mismatch_count = 0;
      beat_no        = 0;
      open_count     = 0;
   end

   function automatic int unsigned wrap_next(int unsigned ptr);
      return (ptr + 1 >= FIFO_DEPTH) ? 0 : ptr + 1;
   endfunction

   function automatic int unsigned fifo_used();
      if (rx_wr_ptr >= rx_rd_ptr)
         return rx_wr_ptr - rx_rd_ptr;
      return FIFO_DEPTH - rx_rd_ptr + rx_wr_ptr;
   endfunction

   function automatic void clear_state();
      baud_ticks    = 0;
      line_inverted = 1'b0;
      listening     = 1'b0;
      rx_wr_ptr     = 0;
      rx_rd_ptr     = 0;
      overrun_seen  = 1'b0;
      rx_state      = RX_IDLE;
      rx_wait       = 0;
      rx_sr         = '0;
      rx_bits       = 0;
      tx_wait       = 0;
      tx_sr         = '0;
      tx_slot       = TX_OFF;
   endfunction

   function automatic void write_register(logic [CSR_INDEX_W-1:0] idx,
                                          logic [CSR_DATA_W-1:0] value);
      case (idx)
         CSR_BIT_PERIOD: begin
            baud_ticks = value;
         end
         CSR_INVERSE_LOGIC: begin
            line_inverted = value[0];
         end
         CSR_LISTEN_ENABLE: begin
            listening = value[0];
            // Turning the receiver on empties the FIFO; turning it off drops a frame.
            if (listening) begin
               rx_wr_ptr    = 0;
               rx_rd_ptr    = 0;
               overrun_seen = 1'b0;
            end else begin
               rx_state = RX_IDLE;
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void receive_tick(logic lvl);
      if (!listening || baud_ticks == 0) begin
         rx_state = RX_IDLE;
         return;
      end
      if (rx_state == RX_IDLE) begin
         if (lvl == line_inverted) begin
            rx_state = RX_CENTER;
            rx_wait  = ((baud_ticks >> 1) == 0) ? 1 : (baud_ticks >> 1);
         end
         return;
      end
      if (rx_wait > 1) begin
         rx_wait--;
         return;
      end
      case (rx_state)
         RX_CENTER: begin
            if (lvl != line_inverted) begin
               rx_state = RX_IDLE;
            end else begin
               rx_state = RX_DATA;
               rx_bits  = 0;
               rx_sr    = '0;
               rx_wait  = baud_ticks;
            end
         end
         RX_DATA: begin
            rx_sr = {lvl ^ line_inverted, rx_sr[7:1]};
            rx_bits++;
            if (rx_bits >= 8) begin
               rx_state = RX_STOP;
               rx_wait  = ((baud_ticks * 3 / 4) == 0) ? 1 : baud_ticks * 3 / 4;
            end else begin
               rx_wait = baud_ticks;
            end
         end
         default: begin
            // The stop bit is not checked; a full FIFO drops the byte.
            if (wrap_next(rx_wr_ptr) == rx_rd_ptr) begin
               overrun_seen = 1'b1;
            end else begin
               rx_fifo_mem[rx_wr_ptr] = rx_sr;
               rx_wr_ptr = wrap_next(rx_wr_ptr);
            end
            rx_state = RX_IDLE;
         end
      endcase
   endfunction

   function automatic rsp_type predict_tick(logic [REQ_USER_W-1:0] cmd, logic [7:0] data,
                                            logic lvl);
      rsp_type     r;
      int unsigned used;
      used = fifo_used();
      r    = '0;
      r.front_byte    = (used != 0) ? rx_fifo_mem[rx_rd_ptr] : 8'd0;
      r.fifo_count    = used[COUNT_W-1:0];
      r.overflow_flag = overrun_seen;
      r.rx_busy       = (rx_state != RX_IDLE);

      if (baud_ticks == 0)
         tx_slot = TX_OFF;
      if (cmd == CMD_SEND && tx_slot == TX_OFF && baud_ticks != 0) begin
         tx_slot = TX_START;
         tx_wait = baud_ticks;
         tx_sr   = data;
         r.send_accepted = 1'b1;
      end

      if (tx_slot == TX_OFF || tx_slot >= TX_STOP)
         r.tx_level = !line_inverted;
      else if (tx_slot == TX_START)
         r.tx_level = line_inverted;
      else
         r.tx_level = tx_sr[0] ^ line_inverted;
      r.tx_busy = (tx_slot != TX_OFF);

      if (tx_slot != TX_OFF) begin
         if (tx_wait > 1) begin
            tx_wait--;
         end else begin
            if (tx_slot > TX_START && tx_slot < TX_STOP)
               tx_sr = tx_sr >> 1;
            tx_slot = (tx_slot >= TX_STOP) ? TX_OFF : tx_slot + 1;
            tx_wait = baud_ticks;
         end
      end

      // Pop and clear act before the receiver may store in the same tick.
      if (cmd == CMD_POP && used != 0)
         rx_rd_ptr = wrap_next(rx_rd_ptr);
      else if (cmd == CMD_CLEAR_OVF)
         overrun_seen = 1'b0;

      receive_tick(lvl);
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      mismatch_count++;
      $display("MISMATCH at status beat %0d: %s is 0x%0h, expected 0x%0h",
               beat_no, what, got, want);
   endtask

   task automatic check_status(input rsp_type got);
      rsp_type want;
      beat_no++;
      if (expected_status_q.size() == 0) begin
         report_mismatch("beat with no tick waiting", got, 0);
         return;
      end
      want = expected_status_q.pop_front();
      if (got.tx_level !== want.tx_level)
         report_mismatch("tx_level", got.tx_level, want.tx_level);
      if (got.tx_busy !== want.tx_busy)
         report_mismatch("tx_busy", got.tx_busy, want.tx_busy);
      if (got.send_accepted !== want.send_accepted)
         report_mismatch("send_accepted", got.send_accepted, want.send_accepted);
      // An empty FIFO shows a zero front byte.
      if (got.front_byte !== want.front_byte)
         report_mismatch("front_byte", got.front_byte, want.front_byte);
      if (got.fifo_count !== want.fifo_count)
         report_mismatch("fifo_count", got.fifo_count, want.fifo_count);
      if (got.overflow_flag !== want.overflow_flag)
         report_mismatch("overflow_flag", got.overflow_flag, want.overflow_flag);
      if (got.rx_busy !== want.rx_busy)
         report_mismatch("rx_busy", got.rx_busy, want.rx_busy);
      if (got.pad !== want.pad)
         report_mismatch("padding", got.pad, want.pad);
   endtask

   // A tick taken in the same cycle as a register write still sees the old settings.
   always @(posedge clock) begin
      if (reset) begin
         clear_state();
         expected_status_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready)
            check_status(rsp_tdata);
         if (req_tvalid && req_tready)
            expected_status_q.push_back(predict_tick(req_tuser, req_tdata[7:0], req_tdata[8]));
         if (csr_valid && csr_ready)
            write_register(csr_index, csr_wdata);
      end
      open_count <= expected_status_q.size();
   end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top: drives ticks, line frames and register writes into the serial block.
`timescale 1ns / 100ps

module tb_top;

   import btu_pkg::*;

   localparam int UART_FIFO_DEPTH = 64;
   localparam int STALL_LIMIT     = 2000;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;
   logic [REQ_USER_W-1:0]  req_tuser  = CMD_TICK;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = CSR_BIT_PERIOD;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   int fail_count;
   int open_count;

   int req_idle_pct  = 0;
   int rsp_stall_pct = 0;
   bit rsp_hold      = 1'b0;
   bit burst_started = 1'b0;
   int quiet_cycles  = 0;
   int ticks_sent    = 0;

   // Receive line levels still to be played out, one per tick.
   bit rx_line_q [$];

   always #1 clock = ~clock;

   bit_timed_uart_8n1_with_rx_fifo #(
      .FIFO_DEPTH (UART_FIFO_DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   uart_status_checker #(
      .FIFO_DEPTH (UART_FIFO_DEPTH)
   ) checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .open_count (open_count)
   );

   always @(posedge clock) begin
      rsp_tready <= !rsp_hold && ($urandom_range(99) >= rsp_stall_pct);
   end

   // Once the burst phase runs, the status side stops taking beats for a long stretch.
   initial begin : status_hold_off
      wait (burst_started);
      repeat (100) @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (60) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Watchdog: no beat moved for %0d cycles", STALL_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic offer_tick(input logic [REQ_USER_W-1:0] cmd, input logic [7:0] data,
                             input logic lvl);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {7'd0, lvl, data};
      do @(posedge clock); while (!req_tready);
      ticks_sent++;
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (open_count != 0) @(posedge clock);
   endtask

   // Appends one stretch of receive line: mostly whole frames, else glitches,
   // frames cut short, or plain noise.
   task automatic queue_rx_chunk(input int unsigned period, input bit inv, input bit clean);
      int unsigned kind;
      int unsigned nbits;
      int unsigned start_len;
      int unsigned k;
      bit [7:0]    data;
      kind      = clean ? 0 : $urandom_range(9);
      data      = 8'($urandom);
      // With one-tick bits the start level must also cover the centering check.
      start_len = (period < 2) ? 2 : period;
      if (kind == 7) begin
         rx_line_q.push_back(inv);
         repeat ($urandom_range(1, 3)) rx_line_q.push_back(!inv);
      end else if (kind == 9) begin
         repeat ($urandom_range(1, 8)) rx_line_q.push_back(1'($urandom_range(1)));
      end else begin
         nbits = (kind == 8) ? $urandom_range(1, 7) : 8;
         repeat (start_len) rx_line_q.push_back(inv);
         for (k = 0; k < nbits; k++)
            repeat (period) rx_line_q.push_back(data[k] ^ inv);
         repeat (period * (10 - nbits) + $urandom_range(0, 2)) rx_line_q.push_back(!inv);
      end
   endtask

   task automatic run_ticks(input int count, input int pop_pct, input int unsigned period,
                            input bit inv, input bit clean);
      int                    pick;
      logic [REQ_USER_W-1:0] cmd;
      bit                    lvl;
      repeat (count) begin
         if (rx_line_q.size() == 0)
            queue_rx_chunk(period, inv, clean);
         lvl  = rx_line_q.pop_front();
         pick = $urandom_range(99);
         if (pick < 8)
            cmd = CMD_SEND;
         else if (pick < 8 + pop_pct)
            cmd = CMD_POP;
         else if (pick < 11 + pop_pct)
            cmd = CMD_CLEAR_OVF;
         else
            cmd = CMD_TICK;
         offer_tick(cmd, 8'($urandom), lvl);
      end
   endtask

   initial begin : stimulus
      req_idle_pct  = 23;
      rsp_stall_pct <= 73;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Bit period still zero: sends are refused, pops find nothing.
      offer_tick(CMD_SEND, 8'hFF, 1'b1);
      offer_tick(CMD_POP, 8'h00, 1'b0);
      offer_tick(CMD_CLEAR_OVF, 8'h00, 1'b1);
      offer_tick(CMD_TICK, 8'h00, 1'b0);
      wait_for_results();
      write_reg(CSR_INVERSE_LOGIC, 16'd0);
      write_reg(CSR_BIT_PERIOD, 16'd2);
      write_reg(CSR_LISTEN_ENABLE, 16'd1);

      // A send, a second send while busy, an empty pop, then a false start.
      offer_tick(CMD_SEND, 8'h00, 1'b1);
      offer_tick(CMD_SEND, 8'hFF, 1'b1);
      offer_tick(CMD_POP, 8'h5A, 1'b1);
      offer_tick(CMD_TICK, 8'hA5, 1'b0);
      offer_tick(CMD_TICK, 8'h00, 1'b1);
      offer_tick(CMD_TICK, 8'h00, 1'b1);

      wait_for_results();
      write_reg(CSR_BIT_PERIOD, 16'd3);
      run_ticks(80, 10, 3, 1'b0, 1'b0);

      // Zero bit period while frames are likely under way drops them.
      wait_for_results();
      write_reg(CSR_BIT_PERIOD, 16'd0);
      offer_tick(CMD_SEND, 8'h3C, 1'b0);
      offer_tick(CMD_TICK, 8'h00, 1'b0);
      wait_for_results();
      write_reg(CSR_INVERSE_LOGIC, 16'd1);
      write_reg(CSR_BIT_PERIOD, 16'd2);
      req_idle_pct  = 73;
      rsp_stall_pct <= 23;
      rx_line_q.delete();
      run_ticks(80, 10, 2, 1'b1, 1'b0);

      // Receiver switched off mid-frame; start levels must not open a new one.
      wait_for_results();
      write_reg(CSR_LISTEN_ENABLE, 16'd0);
      repeat (4) offer_tick(CMD_TICK, 8'h00, 1'b1);
      wait_for_results();
      write_reg(CSR_INVERSE_LOGIC, 16'd0);
      write_reg(CSR_BIT_PERIOD, 16'd1);
      write_reg(CSR_LISTEN_ENABLE, 16'd1);
      req_idle_pct  = 0;
      rsp_stall_pct <= 0;
      rx_line_q.delete();
      burst_started = 1'b1;
      // Back-to-back clean frames with no pops build up the FIFO.
      run_ticks(480, 0, 1, 1'b0, 1'b1);
      run_ticks(60, 12, 1, 1'b0, 1'b0);

      // Longest bit period: both sides wait on long counts until the period is zeroed.
      wait_for_results();
      write_reg(CSR_BIT_PERIOD, 16'hFFFF);
      offer_tick(CMD_SEND, 8'h5A, 1'b0);
      repeat (5) offer_tick(CMD_TICK, 8'h00, 1'b0);
      wait_for_results();
      write_reg(CSR_BIT_PERIOD, 16'd0);
      repeat (3) offer_tick(CMD_TICK, 8'h00, 1'b0);
      wait_for_results();
      write_reg(CSR_LISTEN_ENABLE, 16'd0);
      offer_tick(CMD_SEND, 8'h81, 1'b0);
      offer_tick(CMD_POP, 8'h7E, 1'b1);

      wait_for_results();
      repeat (8) @(posedge clock);
      $display("Ran %0d ticks at bit periods 0, 1, 2, 3 and 65535 with both line polarities,",
               ticks_sent);
      $display("covering receive frames, glitches, a filling FIFO, pops and a long status stall.");
      if (fail_count == 0 && open_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
